[rtl/cst_pkg.sv]
// cst_pkg: shared types, constants and helper functions for the c subset tokenizer
// no dependencies
package cst_pkg;

    localparam int LINE_W_DEF   = 16;
    localparam int COLUMN_W_DEF = 12;
    localparam int KW_CHARS_DEF = 6;
    localparam int LEN_W        = 12;
    localparam int KIND_W       = 6;
    localparam int ERR_W        = 3;

    // lexer modes, one-hot
    typedef enum logic [16:0] {
        M_IDLE       = 17'h00001,
        M_NUM_INT    = 17'h00002,
        M_NUM_FRAC   = 17'h00004,
        M_IDENT      = 17'h00008,
        M_STR        = 17'h00010,
        M_STR_ESC    = 17'h00020,
        M_CHR_OPEN   = 17'h00040,
        M_CHR_ESC    = 17'h00080,
        M_CHR_CLOSE  = 17'h00100,
        M_SLASH      = 17'h00200,
        M_LINE_CMT   = 17'h00400,
        M_BLOCK      = 17'h00800,
        M_BLOCK_STAR = 17'h01000,
        M_PEND_EQ    = 17'h02000,
        M_PEND_BANG  = 17'h04000,
        M_PEND_LT    = 17'h08000,
        M_PEND_GT    = 17'h10000
    } t_mode;

    // token kinds
    localparam logic [KIND_W-1:0] K_NUMBER  = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT   = 6'd1;
    localparam logic [KIND_W-1:0] K_KW_INT  = 6'd2;
    localparam logic [KIND_W-1:0] K_KW_FLT  = 6'd3;
    localparam logic [KIND_W-1:0] K_KW_CHR  = 6'd4;
    localparam logic [KIND_W-1:0] K_KW_VOID = 6'd5;
    localparam logic [KIND_W-1:0] K_KW_IF   = 6'd6;
    localparam logic [KIND_W-1:0] K_KW_ELSE = 6'd7;
    localparam logic [KIND_W-1:0] K_KW_WHL  = 6'd8;
    localparam logic [KIND_W-1:0] K_KW_FOR  = 6'd9;
    localparam logic [KIND_W-1:0] K_KW_RET  = 6'd10;
    localparam logic [KIND_W-1:0] K_STRING  = 6'd11;
    localparam logic [KIND_W-1:0] K_CHAR    = 6'd12;
    localparam logic [KIND_W-1:0] K_EQ      = 6'd13;
    localparam logic [KIND_W-1:0] K_NE      = 6'd14;
    localparam logic [KIND_W-1:0] K_LE      = 6'd15;
    localparam logic [KIND_W-1:0] K_GE      = 6'd16;
    localparam logic [KIND_W-1:0] K_PLUS    = 6'd17;
    localparam logic [KIND_W-1:0] K_MINUS   = 6'd18;
    localparam logic [KIND_W-1:0] K_STAR    = 6'd19;
    localparam logic [KIND_W-1:0] K_DIVIDE  = 6'd20;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd21;
    localparam logic [KIND_W-1:0] K_LT      = 6'd22;
    localparam logic [KIND_W-1:0] K_GT      = 6'd23;
    localparam logic [KIND_W-1:0] K_LPAREN  = 6'd24;
    localparam logic [KIND_W-1:0] K_RPAREN  = 6'd25;
    localparam logic [KIND_W-1:0] K_LBRACE  = 6'd26;
    localparam logic [KIND_W-1:0] K_RBRACE  = 6'd27;
    localparam logic [KIND_W-1:0] K_LBRACK  = 6'd28;
    localparam logic [KIND_W-1:0] K_RBRACK  = 6'd29;
    localparam logic [KIND_W-1:0] K_SEMI    = 6'd30;
    localparam logic [KIND_W-1:0] K_COMMA   = 6'd31;
    localparam logic [KIND_W-1:0] K_UNKNOWN = 6'd32;
    localparam logic [KIND_W-1:0] K_EOF     = 6'd33;

    // error codes
    localparam logic [ERR_W-1:0] E_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] E_COMMENT  = 3'd1;
    localparam logic [ERR_W-1:0] E_STRING   = 3'd2;
    localparam logic [ERR_W-1:0] E_CHAR     = 3'd3;
    localparam logic [ERR_W-1:0] E_UNEXPECT = 3'd4;

    // character constants
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // keyword text, left aligned, zero padded to six bytes
    localparam int KW_NUM = 9;
    localparam int KW_MAX = 6;
    typedef logic [8*KW_MAX-1:0] t_kw_text;
    localparam t_kw_text KW_TEXT [KW_NUM] = '{
        {"int", 24'h0}, {"float", 8'h0}, {"char", 16'h0}, {"void", 16'h0},
        {"if", 32'h0}, {"else", 16'h0}, {"while", 8'h0}, {"for", 24'h0},
        "return"
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd5, 3'd4, 3'd4, 3'd2,
                                               3'd4, 3'd5, 3'd3, 3'd6};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic [31:0]       line;
        logic [23:0]       col;
        logic [LEN_W-1:0]  len;
    } t_tok;

    // results of one step, to the output stage
    typedef struct packed {
        logic  v0;
        logic  v1;
        t_tok  t0;
        t_tok  t1;
    } t_step;

endpackage

[rtl/cst_if.sv]
// cst_stream_if: valid/ready channel carrying a payload of type T
// depends on nothing
interface cst_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/c_subset_tokenizer.sv]
// c_subset_tokenizer: top level, input register, lexer and four-entry result buffer
// depends on cst_pkg, cst_stream_if, cst_lexer
//
// Usage: source bytes enter on the sink channel s_in (char_code, end_of_input); tokens leave
// on the source channel m_out (kind, error, start line/column, length, last_in_run).
// An input transaction is registered, then lexed in the next cycle, where it yields zero,
// one or two tokens; these are written into a four-entry result buffer.
// The first token of a byte leaves from the result buffer, which is written at the end of
// the cycle in which the byte is lexed.
// Throughput: one byte per cycle while the receiver takes one token per cycle; only a run
// of bytes that yield two tokens each, faster than one token per cycle can leave, fills
// the buffer and pauses the input until it drains.
// Input ready is high whenever the buffer will hold at most two tokens after this cycle's
// output and lexer writes, so a stalled receiver stops input once more than two tokens wait.
// An end-of-input flag or a zero byte flushes any pending token, emits end of file and
// restarts the position counters at line 1, column 1.
// Reset (synchronous, active low) empties the input register and the result buffer and
// returns the lexer to its idle state with the counters at line 1, column 1.
module c_subset_tokenizer #(
    parameter int LINE_WIDTH    = cst_pkg::LINE_W_DEF,
    parameter int COLUMN_WIDTH  = cst_pkg::COLUMN_W_DEF,
    parameter int KEYWORD_CHARS = cst_pkg::KW_CHARS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cst_stream_if.sink   s_in,
    cst_stream_if.source m_out
);
    import cst_pkg::*;

    logic        r_iv;
    logic [7:0]  r_char;
    logic        r_eoi;
    t_step       w_res;
    t_tok        r_q [4];
    logic [3:0]  r_qlast;
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [2:0]  r_cnt;
    logic [2:0]  w_cnt_next;
    logic        w_pop;
    logic [2:0]  w_nres;
    logic [1:0]  w_wp1;

    // input register, accepts when the buffer has room for the worst case
    assign w_pop      = m_out.valid && m_out.ready;
    assign w_nres     = r_iv ? ({2'b0, w_res.v0} + {2'b0, w_res.v1}) : 3'd0;
    assign w_cnt_next = r_cnt - {2'b0, w_pop} + w_nres;
    assign s_in.ready = w_cnt_next <= 3'd2;
    assign w_wp1      = r_wp + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else begin
            r_iv <= s_in.valid && s_in.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) begin
            r_char <= s_in.data.char_code;
            r_eoi  <= s_in.data.end_of_input;
        end
    end

    cst_lexer #(.LINE_W(LINE_WIDTH), .COLUMN_W(COLUMN_WIDTH), .KW_CHARS(KEYWORD_CHARS)) u_lex (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(r_iv),
        .i_char(r_char), .i_eoi(r_eoi), .o_res(w_res)
    );

    // result buffer pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            r_cnt <= w_cnt_next;
            r_wp  <= r_wp + w_nres[1:0];
            r_rp  <= r_rp + {1'b0, w_pop};
        end
    end

    // result buffer entries, first token at the write pointer, second right after it
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (r_iv && w_res.v0 && r_wp == 2'(i)) begin
                r_q[i]     <= w_res.t0;
                r_qlast[i] <= !w_res.v1;
            end else if (r_iv && w_res.v1 && w_wp1 == 2'(i)) begin
                r_q[i]     <= w_res.t1;
                r_qlast[i] <= 1'b1;
            end
        end
    end

    // output channel
    assign m_out.valid              = r_cnt != 3'd0;
    assign m_out.data.token_kind    = r_q[r_rp].kind;
    assign m_out.data.error_code    = r_q[r_rp].err;
    assign m_out.data.start_line    = r_q[r_rp].line[15:0];
    assign m_out.data.start_column  = r_q[r_rp].col[11:0];
    assign m_out.data.lexeme_length = r_q[r_rp].len;
    assign m_out.data.last_in_run   = r_qlast[r_rp];
endmodule

[rtl/cst_kw_match.sv]
// cst_kw_match: classifies the kept identifier prefix as identifier or keyword
// depends on cst_pkg
module cst_kw_match #(
    parameter int KW_CHARS = cst_pkg::KW_CHARS_DEF
) (
    input  logic [8*KW_CHARS-1:0]       i_chars,
    input  logic [cst_pkg::LEN_W-1:0]   i_len,
    output logic [cst_pkg::KIND_W-1:0]  o_kind
);
    import cst_pkg::*;

    // compare the length and the six leading bytes against each keyword (keyword text is zero padded)
    always_comb begin
        o_kind = K_IDENT;
        for (int k = 0; k < KW_NUM; k++) begin
            if ((i_len == LEN_W'(KW_LEN[k])) &&
                (i_chars[8*KW_CHARS-1 -: 8*KW_MAX] == KW_TEXT[k])) begin
                o_kind = KIND_W'(K_KW_INT + KIND_W'(k));
            end
        end
    end
endmodule

[rtl/cst_lexer.sv]
// cst_lexer: lexer state, position counters and per-byte token decisions
// depends on cst_pkg, cst_kw_match
module cst_lexer #(
    parameter int LINE_W   = cst_pkg::LINE_W_DEF,
    parameter int COLUMN_W = cst_pkg::COLUMN_W_DEF,
    parameter int KW_CHARS = cst_pkg::KW_CHARS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_char,
    input  logic           i_eoi,
    output cst_pkg::t_step o_res
);
    import cst_pkg::*;

    localparam logic [LINE_W-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_W-1:0] COL_MAX  = '1;
    localparam logic [LEN_W-1:0]    LEN_MAX  = '1;

    t_mode               r_mode, n_mode;
    logic [LINE_W-1:0]   r_line, n_line, r_sline, n_sline;
    logic [COLUMN_W-1:0] r_col, n_col, r_scol, n_scol;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [8*KW_CHARS-1:0] r_chars, n_chars;
    logic [KIND_W-1:0]   w_id_kind;
    logic                w_end;
    logic [LEN_W-1:0]    w_grow;

    cst_kw_match #(.KW_CHARS(KW_CHARS)) u_kw (
        .i_chars(r_chars), .i_len(r_len), .o_kind(w_id_kind)
    );

    function automatic t_tok mk(input logic [KIND_W-1:0] k, input logic [ERR_W-1:0] e,
                                input logic [LINE_W-1:0] l, input logic [COLUMN_W-1:0] c,
                                input logic [LEN_W-1:0] n);
        t_tok t;
        t.kind = k;
        t.err  = e;
        t.line = 32'(l);
        t.col  = 24'(c);
        t.len  = n;
        return t;
    endfunction

    assign w_end  = i_eoi || (i_char == 8'd0);
    assign w_grow = (r_len < LEN_MAX) ? r_len + 1'b1 : r_len;

    // next state and results of one byte
    always_comb begin
        logic       disp;
        logic       pend;
        logic [KIND_W-1:0] pk;
        logic [ERR_W-1:0]  pe;
        t_tok       tp, td;
        logic       vd;
        disp    = 1'b0;
        pend    = 1'b0;
        pk      = K_NUMBER;
        pe      = E_NONE;
        vd      = 1'b0;
        td      = mk(K_UNKNOWN, E_UNEXPECT, r_line, r_col, LEN_W'(1));
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_len   = r_len;
        n_chars = r_chars;
        o_res   = '0;
        if (w_end) begin
            // flush pending token, then end of file, then reset
            pe = E_NONE;
            unique case (r_mode)
                M_NUM_INT, M_NUM_FRAC: begin pend = 1'b1; pk = K_NUMBER; end
                M_IDENT: begin pend = 1'b1; pk = w_id_kind; end
                M_STR, M_STR_ESC: begin pend = 1'b1; pk = K_STRING; pe = E_STRING; end
                M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE: begin
                    pend = 1'b1; pk = K_CHAR; pe = E_CHAR;
                end
                M_SLASH: begin pend = 1'b1; pk = K_DIVIDE; end
                M_PEND_EQ: begin pend = 1'b1; pk = K_ASSIGN; end
                M_PEND_BANG: begin pend = 1'b1; pk = K_UNKNOWN; pe = E_UNEXPECT; end
                M_PEND_LT: begin pend = 1'b1; pk = K_LT; end
                M_PEND_GT: begin pend = 1'b1; pk = K_GT; end
                default: ;
            endcase
            tp = mk(pk, pe, r_sline, r_scol, r_len);
            td = mk(K_EOF, (r_mode == M_BLOCK || r_mode == M_BLOCK_STAR) ? E_COMMENT : E_NONE,
                    r_line, r_col, '0);
            if (pend) begin
                o_res.v0 = 1'b1; o_res.t0 = tp; o_res.v1 = 1'b1; o_res.t1 = td;
            end else begin
                o_res.v0 = 1'b1; o_res.t0 = td;
            end
            n_mode  = M_IDLE;
            n_line  = LINE_W'(1);
            n_col   = COLUMN_W'(1);
            n_sline = '0;
            n_scol  = '0;
            n_len   = '0;
            n_chars = '0;
        end else begin
            unique case (r_mode)
                M_NUM_INT: begin
                    if (is_digit(i_char)) n_len = w_grow;
                    else if (i_char == ".") begin n_len = w_grow; n_mode = M_NUM_FRAC; end
                    else begin pend = 1'b1; pk = K_NUMBER; disp = 1'b1; end
                end
                M_NUM_FRAC: begin
                    if (is_digit(i_char)) n_len = w_grow;
                    else begin pend = 1'b1; pk = K_NUMBER; disp = 1'b1; end
                end
                M_IDENT: begin
                    if (is_letter(i_char) || is_digit(i_char)) begin
                        for (int i = 0; i < KW_CHARS; i++) begin
                            if (r_len == LEN_W'(i)) n_chars[8*(KW_CHARS-1-i) +: 8] = i_char;
                        end
                        n_len = w_grow;
                    end else begin
                        pend = 1'b1; pk = w_id_kind; disp = 1'b1;
                    end
                end
                M_STR: begin
                    n_len = w_grow;
                    if (i_char == "\\") n_mode = M_STR_ESC;
                    else if (i_char == "\"") begin
                        o_res.v0 = 1'b1;
                        o_res.t0 = mk(K_STRING, E_NONE, r_sline, r_scol, w_grow);
                        n_mode = M_IDLE;
                    end
                end
                M_STR_ESC: begin n_len = w_grow; n_mode = M_STR; end
                M_CHR_OPEN: begin
                    n_len = w_grow;
                    n_mode = (i_char == "\\") ? M_CHR_ESC : M_CHR_CLOSE;
                end
                M_CHR_ESC: begin n_len = w_grow; n_mode = M_CHR_CLOSE; end
                M_CHR_CLOSE: begin
                    if (i_char == "'") begin
                        n_len = w_grow;
                        o_res.v0 = 1'b1;
                        o_res.t0 = mk(K_CHAR, E_NONE, r_sline, r_scol, w_grow);
                        n_mode = M_IDLE;
                    end else begin
                        pend = 1'b1; pk = K_CHAR; pe = E_CHAR; disp = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (i_char == "/") n_mode = M_LINE_CMT;
                    else if (i_char == "*") n_mode = M_BLOCK;
                    else begin pend = 1'b1; pk = K_DIVIDE; disp = 1'b1; end
                end
                M_LINE_CMT: if (i_char == CH_NL) n_mode = M_IDLE;
                M_BLOCK: if (i_char == "*") n_mode = M_BLOCK_STAR;
                M_BLOCK_STAR: begin
                    if (i_char == "/") n_mode = M_IDLE;
                    else if (i_char != "*") n_mode = M_BLOCK;
                end
                M_PEND_EQ, M_PEND_BANG, M_PEND_LT, M_PEND_GT: begin
                    if (i_char == "=") begin
                        n_len = LEN_W'(2);
                        o_res.v0 = 1'b1;
                        o_res.t0 = mk((r_mode == M_PEND_EQ) ? K_EQ :
                                      (r_mode == M_PEND_BANG) ? K_NE :
                                      (r_mode == M_PEND_LT) ? K_LE : K_GE,
                                      E_NONE, r_sline, r_scol, LEN_W'(2));
                        n_mode = M_IDLE;
                    end else begin
                        pend = 1'b1;
                        disp = 1'b1;
                        pk = (r_mode == M_PEND_EQ) ? K_ASSIGN :
                             (r_mode == M_PEND_BANG) ? K_UNKNOWN :
                             (r_mode == M_PEND_LT) ? K_LT : K_GT;
                        pe = (r_mode == M_PEND_BANG) ? E_UNEXPECT : E_NONE;
                    end
                end
                default: disp = 1'b1;
            endcase
            // start of a new lexeme at this byte
            if (disp) begin
                n_mode = M_IDLE;
                if (is_space(i_char)) begin
                end else if (is_digit(i_char) || is_letter(i_char) || i_char == "\"" ||
                             i_char == "'" || i_char == "/" || i_char == "=" ||
                             i_char == "!" || i_char == "<" || i_char == ">") begin
                    n_sline = r_line;
                    n_scol  = r_col;
                    n_len   = LEN_W'(1);
                    if (is_digit(i_char)) n_mode = M_NUM_INT;
                    else if (is_letter(i_char)) begin
                        n_mode  = M_IDENT;
                        n_chars = '0;
                        n_chars[8*KW_CHARS-1 -: 8] = i_char;
                    end else if (i_char == "\"") n_mode = M_STR;
                    else if (i_char == "'") n_mode = M_CHR_OPEN;
                    else if (i_char == "/") n_mode = M_SLASH;
                    else if (i_char == "=") n_mode = M_PEND_EQ;
                    else if (i_char == "!") n_mode = M_PEND_BANG;
                    else if (i_char == "<") n_mode = M_PEND_LT;
                    else n_mode = M_PEND_GT;
                end else begin
                    vd = 1'b1;
                    td = mk(K_UNKNOWN, E_UNEXPECT, r_line, r_col, LEN_W'(1));
                    unique case (i_char)
                        "+": td.kind = K_PLUS;
                        "-": td.kind = K_MINUS;
                        "*": td.kind = K_STAR;
                        "(": td.kind = K_LPAREN;
                        ")": td.kind = K_RPAREN;
                        "{": td.kind = K_LBRACE;
                        "}": td.kind = K_RBRACE;
                        "[": td.kind = K_LBRACK;
                        "]": td.kind = K_RBRACK;
                        ";": td.kind = K_SEMI;
                        ",": td.kind = K_COMMA;
                        default: ;
                    endcase
                    if (td.kind != K_UNKNOWN) td.err = E_NONE;
                end
            end
            // pack the pending flush and the dispatched token in order
            tp = mk(pk, pe, r_sline, r_scol, r_len);
            if (pend) begin
                o_res.v0 = 1'b1; o_res.t0 = tp;
                o_res.v1 = vd;   o_res.t1 = td;
            end else if (vd) begin
                o_res.v0 = 1'b1; o_res.t0 = td;
            end
            // position counters
            if (i_char == CH_NL) begin
                if (r_line < LINE_MAX) n_line = r_line + 1'b1;
                n_col = COLUMN_W'(1);
            end else if (r_col < COL_MAX) begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= LINE_W'(1);
            r_col   <= COLUMN_W'(1);
            r_sline <= '0;
            r_scol  <= '0;
            r_len   <= '0;
            r_chars <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_len   <= n_len;
            r_chars <= n_chars;
        end
    end
endmodule

[rtl/cst_checker.sv]
// cst_checker: port-level assertions for c_subset_tokenizer, bound to the top level
// depends on cst_pkg
module cst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] kind,
    input logic [2:0] err,
    input logic [15:0] line
);
    import cst_pkg::*;

    // output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind))
        else $error("stalled token changed");

    // nothing comes out without input having been taken
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(out_valid))
        else $error("token without transaction");

    // error code in range
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> err <= E_UNEXPECT)
        else $error("bad error code");

    // tokens start at line one or later
    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> line != 16'd0)
        else $error("zero line");
endmodule

bind c_subset_tokenizer cst_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .kind(m_out.data.token_kind), .err(m_out.data.error_code),
    .line(m_out.data.start_line)
);

[sim/cst_tb_pkg.sv]
// cst_tb_pkg: payload types of the tokenizer's input and token channels for simulation
// depends on cst_pkg
package cst_tb_pkg;

    // one source byte transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_src_item;

    // one token transaction
    typedef struct packed {
        logic [cst_pkg::KIND_W-1:0] token_kind;
        logic [cst_pkg::ERR_W-1:0]  error_code;
        logic [15:0]                start_line;
        logic [11:0]                start_column;
        logic [cst_pkg::LEN_W-1:0]  lexeme_length;
        logic                       last_in_run;
    } t_token_item;

endpackage

[sim/cst_token_checker.sv]
// cst_token_checker: watches both channels of the tokenizer, predicts tokens, compares
// depends on cst_pkg, cst_tb_pkg, cst_stream_if
module cst_token_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cst_stream_if.sink s_mon,
    cst_stream_if.sink t_mon,
    output int o_fail_count,
    output int o_tokens_pending
);
    import cst_pkg::*;
    import cst_tb_pkg::*;

    localparam int LINE_TOP = 65535;
    localparam int COL_TOP  = 4095;
    localparam int LEN_TOP  = 4095;

    t_token_item tok_expect_q[$];
    t_token_item step_toks[$];

    t_mode      lx_mode;
    int         cur_line, cur_col, tk_line, tk_col, tk_len;
    logic [7:0] name_buf [KW_MAX];

    function automatic void add_tok(int kind, int err, int ln, int col, int len);
        t_token_item t;
        if (step_toks.size() >= 2) return;
        t.token_kind    = kind[KIND_W-1:0];
        t.error_code    = err[ERR_W-1:0];
        t.start_line    = ln[15:0];
        t.start_column  = col[11:0];
        t.lexeme_length = (len > LEN_TOP) ? LEN_TOP[11:0] : len[11:0];
        t.last_in_run   = 1'b0;
        step_toks = {step_toks, t};
    endfunction

    function automatic void add_pending(int kind, int err);
        add_tok(kind, err, tk_line, tk_col, tk_len);
    endfunction

    function automatic void lengthen();
        if (tk_len < LEN_TOP) tk_len++;
    endfunction

    function automatic int name_kind();
        int i;
        logic hit;
        for (int k = 0; k < KW_NUM; k++) begin
            if (tk_len != int'(KW_LEN[k])) continue;
            hit = 1'b1;
            for (i = 0; i < int'(KW_LEN[k]); i++)
                if (name_buf[i] != KW_TEXT[k][8*KW_MAX-1-8*i -: 8]) hit = 1'b0;
            if (hit) return int'(K_KW_INT) + k;
        end
        return int'(K_IDENT);
    endfunction

    function automatic void open_tok(t_mode m, int ln, int col);
        lx_mode = m;
        tk_line = ln;
        tk_col  = col;
        tk_len  = 1;
    endfunction

    function automatic void start_byte(logic [7:0] c, int ln, int col);
        int kind;
        lx_mode = M_IDLE;
        kind = -1;
        if (is_space(c)) return;
        if (is_digit(c)) begin
            open_tok(M_NUM_INT, ln, col);
            return;
        end
        if (is_letter(c)) begin
            for (int i = 0; i < KW_MAX; i++) name_buf[i] = 8'h00;
            name_buf[0] = c;
            open_tok(M_IDENT, ln, col);
            return;
        end
        case (c)
            "\"": open_tok(M_STR, ln, col);
            "'":  open_tok(M_CHR_OPEN, ln, col);
            "/":  open_tok(M_SLASH, ln, col);
            "=":  open_tok(M_PEND_EQ, ln, col);
            "!":  open_tok(M_PEND_BANG, ln, col);
            "<":  open_tok(M_PEND_LT, ln, col);
            ">":  open_tok(M_PEND_GT, ln, col);
            "+":  kind = K_PLUS;
            "-":  kind = K_MINUS;
            "*":  kind = K_STAR;
            "(":  kind = K_LPAREN;
            ")":  kind = K_RPAREN;
            "{":  kind = K_LBRACE;
            "}":  kind = K_RBRACE;
            "[":  kind = K_LBRACK;
            "]":  kind = K_RBRACK;
            ";":  kind = K_SEMI;
            ",":  kind = K_COMMA;
            default: add_tok(K_UNKNOWN, E_UNEXPECT, ln, col, 1);
        endcase
        if (kind >= 0) add_tok(kind, E_NONE, ln, col, 1);
    endfunction

    function automatic void pair_or_single(int two_k, int one_k, int one_e,
                                           logic [7:0] c, int ln, int col);
        if (c == "=") begin
            tk_len = 2;
            add_pending(two_k, E_NONE);
            lx_mode = M_IDLE;
        end else begin
            add_pending(one_k, one_e);
            start_byte(c, ln, col);
        end
    endfunction

    function automatic void clear_lexer();
        lx_mode  = M_IDLE;
        cur_line = 1;
        cur_col  = 1;
        tk_line  = 0;
        tk_col   = 0;
        tk_len   = 0;
        for (int i = 0; i < KW_MAX; i++) name_buf[i] = 8'h00;
    endfunction

    // end of input: flush pending token, then end of file
    function automatic void end_source();
        int err;
        err = E_NONE;
        case (lx_mode)
            M_NUM_INT, M_NUM_FRAC:             add_pending(K_NUMBER, E_NONE);
            M_IDENT:                           add_pending(name_kind(), E_NONE);
            M_STR, M_STR_ESC:                  add_pending(K_STRING, E_STRING);
            M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE: add_pending(K_CHAR, E_CHAR);
            M_SLASH:                           add_pending(K_DIVIDE, E_NONE);
            M_BLOCK, M_BLOCK_STAR:             err = E_COMMENT;
            M_PEND_EQ:                         add_pending(K_ASSIGN, E_NONE);
            M_PEND_BANG:                       add_pending(K_UNKNOWN, E_UNEXPECT);
            M_PEND_LT:                         add_pending(K_LT, E_NONE);
            M_PEND_GT:                         add_pending(K_GT, E_NONE);
            default: ;
        endcase
        add_tok(K_EOF, err, cur_line, cur_col, 0);
        clear_lexer();
    endfunction

    // tokens caused by one source byte
    function automatic void lex_byte(t_src_item it);
        logic [7:0] c;
        int ln, col;
        c = it.char_code;
        ln = cur_line;
        col = cur_col;
        step_toks.delete();
        if (it.end_of_input || c == 8'h00) begin
            end_source();
        end else begin
            case (lx_mode)
                M_NUM_INT:
                    if (is_digit(c)) lengthen();
                    else if (c == ".") begin
                        lengthen();
                        lx_mode = M_NUM_FRAC;
                    end else begin
                        add_pending(K_NUMBER, E_NONE);
                        start_byte(c, ln, col);
                    end
                M_NUM_FRAC:
                    if (is_digit(c)) lengthen();
                    else begin
                        add_pending(K_NUMBER, E_NONE);
                        start_byte(c, ln, col);
                    end
                M_IDENT:
                    if (is_letter(c) || is_digit(c)) begin
                        if (tk_len < KW_MAX) name_buf[tk_len] = c;
                        lengthen();
                    end else begin
                        add_pending(name_kind(), E_NONE);
                        start_byte(c, ln, col);
                    end
                M_STR: begin
                    lengthen();
                    if (c == "\\") lx_mode = M_STR_ESC;
                    else if (c == "\"") begin
                        add_pending(K_STRING, E_NONE);
                        lx_mode = M_IDLE;
                    end
                end
                M_STR_ESC: begin
                    lengthen();
                    lx_mode = M_STR;
                end
                M_CHR_OPEN: begin
                    lengthen();
                    lx_mode = (c == "\\") ? M_CHR_ESC : M_CHR_CLOSE;
                end
                M_CHR_ESC: begin
                    lengthen();
                    lx_mode = M_CHR_CLOSE;
                end
                M_CHR_CLOSE:
                    if (c == "'") begin
                        lengthen();
                        add_pending(K_CHAR, E_NONE);
                        lx_mode = M_IDLE;
                    end else begin
                        add_pending(K_CHAR, E_CHAR);
                        start_byte(c, ln, col);
                    end
                M_SLASH:
                    if (c == "/") lx_mode = M_LINE_CMT;
                    else if (c == "*") lx_mode = M_BLOCK;
                    else begin
                        add_pending(K_DIVIDE, E_NONE);
                        start_byte(c, ln, col);
                    end
                M_LINE_CMT:   if (c == CH_NL) lx_mode = M_IDLE;
                M_BLOCK:      if (c == "*") lx_mode = M_BLOCK_STAR;
                M_BLOCK_STAR:
                    if (c == "/") lx_mode = M_IDLE;
                    else if (c != "*") lx_mode = M_BLOCK;
                M_PEND_EQ:   pair_or_single(K_EQ, K_ASSIGN, E_NONE, c, ln, col);
                M_PEND_BANG: pair_or_single(K_NE, K_UNKNOWN, E_UNEXPECT, c, ln, col);
                M_PEND_LT:   pair_or_single(K_LE, K_LT, E_NONE, c, ln, col);
                M_PEND_GT:   pair_or_single(K_GE, K_GT, E_NONE, c, ln, col);
                default:     start_byte(c, ln, col);
            endcase
            // position counters
            if (c == CH_NL) begin
                if (cur_line < LINE_TOP) cur_line++;
                cur_col = 1;
            end else if (cur_col < COL_TOP) begin
                cur_col++;
            end
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_in_run = 1'b1;
        foreach (step_toks[i]) tok_expect_q = {tok_expect_q, step_toks[i]};
    endfunction

    // predict on input transactions, compare on token transactions
    always @(posedge i_clk) begin
        t_token_item got, want;
        if (!i_rst_n) begin
            clear_lexer();
            tok_expect_q.delete();
        end else begin
            if (s_mon.valid && s_mon.ready) lex_byte(s_mon.data);
            if (t_mon.valid && t_mon.ready) begin
                got = t_mon.data;
                if (tok_expect_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected token: %p", got);
                end else begin
                    want = tok_expect_q.pop_front();
                    if (got.token_kind !== want.token_kind
                        || got.error_code !== want.error_code
                        || got.start_line !== want.start_line
                        || got.start_column !== want.start_column
                        || got.lexeme_length !== want.lexeme_length
                        || got.last_in_run !== want.last_in_run) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("token mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
        o_tokens_pending = tok_expect_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_tokens_pending = 0;
        clear_lexer();
    end

endmodule

[sim/c_subset_tokenizer_tb.sv]
// c_subset_tokenizer_tb: stimulus, flow control and verdict for the c subset tokenizer
// depends on cst_pkg, cst_tb_pkg, cst_stream_if, cst_token_checker, c_subset_tokenizer
module c_subset_tokenizer_tb;
    import cst_pkg::*;
    import cst_tb_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_gap_pct = 0;
    int   take_stall_pct = 0;
    int   hold_cycles = 0;
    logic hold_req = 1'b0;
    logic in_ready_seen = 1'b0;
    int   idle_cycles = 0;
    int   fail_count, tokens_pending;

    cst_stream_if #(.T(t_src_item))   src_ch (i_clk);
    cst_stream_if #(.T(t_token_item)) tok_ch (i_clk);

    c_subset_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (src_ch.sink),
        .m_out   (tok_ch.source)
    );

    cst_token_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_mon            (src_ch.sink),
        .t_mon            (tok_ch.sink),
        .o_fail_count     (fail_count),
        .o_tokens_pending (tokens_pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        src_ch.valid = 1'b0;
        src_ch.data  = '0;
        tok_ch.ready = 1'b0;
    end

    // ready seen half a cycle ahead, stable across the next rising edge
    always @(negedge i_clk) in_ready_seen <= src_ch.ready;

    // token receiver with random stalls and a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_cycles == 0) hold_cycles <= 300;
        else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
        if (hold_cycles > 1 || (hold_req && hold_cycles == 0))
            tok_ch.ready <= 1'b0;
        else
            tok_ch.ready <= ($urandom_range(99) >= take_stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge that accepts the byte, valid still high
    task automatic send_byte(input logic [7:0] c, input logic eoi);
        t_src_item it;
        it.char_code    = c;
        it.end_of_input = eoi;
        while ($urandom_range(99) < send_gap_pct) begin
            src_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        src_ch.valid <= 1'b1;
        src_ch.data  <= it;
        do @(posedge i_clk); while (!in_ready_seen);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // one random fragment of source text
    task automatic send_fragment();
        string frag;
        int sel;
        sel = $urandom_range(99);
        frag = "";
        if (sel < 15) begin
            case ($urandom_range(8))
                0: frag = "int"; 1: frag = "float"; 2: frag = "char"; 3: frag = "void";
                4: frag = "if"; 5: frag = "else"; 6: frag = "while"; 7: frag = "for";
                default: frag = "return";
            endcase
        end else if (sel < 30) begin
            repeat ($urandom_range(1, 9)) begin
                case ($urandom_range(3))
                    0: frag = {frag, "_"};
                    1: frag = {frag, string'(8'($urandom_range("a", "z")))};
                    2: frag = {frag, string'(8'($urandom_range("A", "Z")))};
                    default: frag = {frag, string'(8'($urandom_range("0", "9")))};
                endcase
            end
            if (frag[0] >= "0" && frag[0] <= "9") frag = {"x", frag};
        end else if (sel < 42) begin
            repeat ($urandom_range(1, 4)) frag = {frag, string'(8'($urandom_range("0", "9")))};
            if ($urandom_range(1)) frag = {frag, "."};
            repeat ($urandom_range(0, 3)) frag = {frag, string'(8'($urandom_range("0", "9")))};
        end else if (sel < 50) begin
            frag = "\"";
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(4) == 0) frag = {frag, "\\"};
                frag = {frag, string'(8'($urandom_range(32, 126)))};
            end
            if ($urandom_range(9) != 0) frag = {frag, "\""};
        end else if (sel < 56) begin
            frag = "'";
            if ($urandom_range(3) == 0) frag = {frag, "\\"};
            frag = {frag, string'(8'($urandom_range(32, 126)))};
            if ($urandom_range(7) != 0) frag = {frag, "'"};
        end else if (sel < 60) begin
            frag = ($urandom_range(1)) ? "// note x\n" : "/* a * b **/";
        end else if (sel < 80) begin
            case ($urandom_range(19))
                0: frag = "=="; 1: frag = "!="; 2: frag = "<="; 3: frag = ">=";
                4: frag = "+"; 5: frag = "-"; 6: frag = "*"; 7: frag = "/";
                8: frag = "="; 9: frag = "<"; 10: frag = ">"; 11: frag = "(";
                12: frag = ")"; 13: frag = "{"; 14: frag = "}"; 15: frag = "[";
                16: frag = "]"; 17: frag = ";"; 18: frag = ",";
                default: frag = "!";
            endcase
        end else if (sel < 92) begin
            case ($urandom_range(3))
                0: frag = " "; 1: frag = "\n"; 2: frag = "\t";
                default: frag = string'(8'($urandom_range(11, 13)));
            endcase
        end else if (sel < 98) begin
            send_byte(8'($urandom_range(1, 255)), 1'b0);
        end else begin
            send_byte(($urandom_range(1)) ? 8'h00 : 8'($urandom_range(255)), 1'b1);
        end
        send_text(frag);
    endtask

    // stop offering and wait until every predicted token has come out
    task automatic drain();
        src_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (tokens_pending == 0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: keywords, names, numbers, literals, operators, comments, errors
        send_text("int float char void if else while for return x_1 abcdefg 12 3.45 7. ");
        send_text("\"s\\\"x\" 'a' '\\n' 'ab == != <= >= = ! < > + - * / ( ) { } [ ] ; , ");
        send_text("// line\n/* b ** */ @ 1/2");
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("\"abc");
        send_byte(8'hFF, 1'b1);
        send_text("'x");
        send_byte(8'h00, 1'b1);
        send_text("/* open");
        send_byte(8'h00, 1'b0);
        send_text("!");
        send_byte(8'h00, 1'b0);
        send_text("=");
        send_byte(8'h00, 1'b1);

        // random text through the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_gap_pct = 0;  take_stall_pct = 0;  end
                1: begin send_gap_pct = 57; take_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  take_stall_pct = 57; end
                default: begin send_gap_pct = 20; take_stall_pct = 20; end
            endcase
            if (ph == 2) begin
                hold_req = 1'b1;
                wait (hold_cycles != 0);
                hold_req = 1'b0;
            end
            repeat (48) send_fragment();
            if (ph == 1) drain();
        end
        send_byte(8'h00, 1'b1);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && tokens_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
